// ===== sv/ptt_pkg.sv =====
// Shared types and codes for the periodic task timer table.
`default_nettype none

package ptt_pkg;

  localparam int ID_W     = 16;
  localparam int PERIOD_W = 20;
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 3;
  localparam int CMD_W    = 2;

  // Most results that one tick may report.
  localparam int MAX_RESULTS = 32;
  localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [CMD_W-1:0] CMD_ONESHOT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd3;

  localparam logic [KIND_W-1:0] EV_ONESHOT   = 3'd0;
  localparam logic [KIND_W-1:0] EV_FIRED     = 3'd1;
  localparam logic [KIND_W-1:0] EV_ADDED     = 3'd2;
  localparam logic [KIND_W-1:0] EV_DUPLICATE = 3'd3;
  localparam logic [KIND_W-1:0] EV_REMOVED   = 3'd4;
  localparam logic [KIND_W-1:0] EV_NOTFOUND  = 3'd5;
  localparam logic [KIND_W-1:0] EV_FULL      = 3'd6;

  // One table entry as it sits in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   due;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/ptt_alu.sv =====
// Shared time unit: saturating due-time adder and due compare.
`default_nettype none

module ptt_alu (
  input  wire logic [ptt_pkg::TIME_W-1:0]   now,
  input  wire logic [ptt_pkg::PERIOD_W-1:0] period,
  input  wire logic [ptt_pkg::TIME_W-1:0]   due,
  output logic      [ptt_pkg::TIME_W-1:0]   due_next,
  output logic                              is_due
);

  logic [ptt_pkg::TIME_W:0] sum;

  always_comb begin
    sum = {1'b0, now} + {{(ptt_pkg::TIME_W + 1 - ptt_pkg::PERIOD_W){1'b0}}, period};
    // A carry out means the sum passed the end of time; hold it at all ones.
    if (sum[ptt_pkg::TIME_W]) begin
      due_next = {ptt_pkg::TIME_W{1'b1}};
    end else begin
      due_next = sum[ptt_pkg::TIME_W-1:0];
    end
    is_due = (due <= now);
  end

endmodule

`default_nettype wire

// ===== sv/ptt_mem.sv =====
// Slot memory: one write port, one registered read port.
`default_nettype none

module ptt_mem #(
  parameter int SLOTS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(SLOTS)-1:0]   waddr,
  input  wire ptt_pkg::entry_t            wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(SLOTS)-1:0]   raddr,
  output ptt_pkg::entry_t                 rdata
);

  ptt_pkg::entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/periodic_task_timer_table_core.sv =====
// Top level of the periodic task timer table: command sequencer and slot scan.
`default_nettype none

// Periodic task timer table. A command is taken when start is high and busy is
// low. A one-shot run is answered in the next cycle and leaves busy low, so
// one-shot commands may follow each other every cycle. Add, remove and tick
// walk the whole table through the slot memory, one slot per cycle, and busy
// stays high through the scan and the done state after it; the scan length
// is set by the single read port of the slot memory. Each result is shown on
// task_id_res, event_kind and last for exactly one cycle while result_strobe
// is high, and the receiver cannot hold it off. last marks the final result of
// a command. A tick reports fired tasks in slot order; because the last one is
// only known when the scan ends, each fired result is sent one find later, and
// the final one is sent from the done state. A tick with nothing due gives no
// transfer at all. At most 32 tasks fire on one tick; tasks due beyond that
// stay due for the next tick. Due times saturate at the largest time value.
module periodic_task_timer_table_core #(
  parameter int SLOTS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [ptt_pkg::CMD_W-1:0]        command,
  input  wire logic [ptt_pkg::ID_W-1:0]         task_id,
  input  wire logic [ptt_pkg::PERIOD_W-1:0]     interval,
  input  wire logic [ptt_pkg::TIME_W-1:0]       now,
  output logic                                  result_strobe,
  output logic      [ptt_pkg::ID_W-1:0]         task_id_res,
  output logic      [ptt_pkg::KIND_W-1:0]       event_kind,
  output logic                                  last
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;

  // Command held for the length of the scan.
  logic [ptt_pkg::CMD_W-1:0]    cmd_q;
  logic [ptt_pkg::ID_W-1:0]     id_q;
  logic [ptt_pkg::PERIOD_W-1:0] interval_q;
  logic [ptt_pkg::TIME_W-1:0]   now_q;

  logic [SLOTS-1:0] slot_valid;

  // Read side of the scan and the evaluate stage registered behind it.
  logic          issue_on;
  logic [IW-1:0] issue_idx;
  logic          eval_vld;
  logic [IW-1:0] eval_idx;

  // Scan findings.
  logic          match_found;
  logic          free_found;
  logic [IW-1:0] free_idx;

  // Tick: held fired result and the count of fired slots.
  logic                              pend_vld;
  logic [ptt_pkg::ID_W-1:0]          pend_id;
  logic [ptt_pkg::FIRE_CNT_W-1:0]    fire_cnt;

  ptt_pkg::entry_t             rd_entry;
  ptt_pkg::entry_t             wr_entry;
  logic                        mem_we;
  logic [IW-1:0]               mem_waddr;
  logic [ptt_pkg::PERIOD_W-1:0] alu_period;
  logic [ptt_pkg::TIME_W-1:0]  alu_due_next;
  logic                        alu_is_due;
  logic                        eval_valid_slot;
  logic                        eval_id_hit;
  logic                        fire;
  logic                        add_commit;

  assign busy = (state != ST_IDLE);

  // In the final cycle of an add the shared unit works on the new interval;
  // during the scan it works on the period of the slot just read.
  assign alu_period = (state == ST_DONE) ? interval_q : rd_entry.period;

  ptt_alu u_alu (
    .now      (now_q),
    .period   (alu_period),
    .due      (rd_entry.due),
    .due_next (alu_due_next),
    .is_due   (alu_is_due)
  );

  assign eval_valid_slot = eval_vld && slot_valid[eval_idx];
  assign eval_id_hit     = eval_valid_slot && (rd_entry.id == id_q);

  // A due slot fires only while the per-tick result budget lasts.
  assign fire = (state == ST_SCAN) && (cmd_q == ptt_pkg::CMD_TICK) && eval_valid_slot
                && alu_is_due && (fire_cnt < ptt_pkg::FIRE_CNT_W'(ptt_pkg::MAX_RESULTS));

  assign add_commit = (state == ST_DONE) && (cmd_q == ptt_pkg::CMD_ADD)
                      && !match_found && free_found;

  always_comb begin
    mem_we    = fire || add_commit;
    mem_waddr = add_commit ? free_idx : eval_idx;
    if (add_commit) begin
      wr_entry.id     = id_q;
      wr_entry.period = interval_q;
    end else begin
      wr_entry.id     = rd_entry.id;
      wr_entry.period = rd_entry.period;
    end
    wr_entry.due = alu_due_next;
  end

  ptt_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_entry),
    .re    (issue_on),
    .raddr (issue_idx),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_valid    <= '0;
      issue_on      <= 1'b0;
      eval_vld      <= 1'b0;
      pend_vld      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      eval_vld      <= issue_on;
      eval_idx      <= issue_idx;

      if (issue_on) begin
        if (issue_idx == LAST_IDX) begin
          issue_on <= 1'b0;
        end else begin
          issue_idx <= issue_idx + 1'b1;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q      <= command;
            id_q       <= task_id;
            interval_q <= interval;
            now_q      <= now;
            if (command == ptt_pkg::CMD_ONESHOT) begin
              // A one-shot run never touches the table.
              result_strobe <= 1'b1;
              task_id_res   <= task_id;
              event_kind    <= ptt_pkg::EV_ONESHOT;
              last          <= 1'b1;
            end else begin
              state       <= ST_SCAN;
              issue_on    <= 1'b1;
              issue_idx   <= '0;
              match_found <= 1'b0;
              free_found  <= 1'b0;
              pend_vld    <= 1'b0;
              fire_cnt    <= '0;
            end
          end
        end

        ST_SCAN: begin
          if (eval_vld) begin
            case (cmd_q)
              ptt_pkg::CMD_ADD: begin
                if (eval_id_hit) begin
                  match_found <= 1'b1;
                end
                if (!slot_valid[eval_idx] && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= eval_idx;
                end
              end
              ptt_pkg::CMD_REMOVE: begin
                // Ids are unique in the table, so the first hit is the only one.
                if (eval_id_hit && !match_found) begin
                  match_found          <= 1'b1;
                  slot_valid[eval_idx] <= 1'b0;
                end
              end
              ptt_pkg::CMD_TICK: begin
                if (fire) begin
                  // The held result is now known not to be the final one.
                  if (pend_vld) begin
                    result_strobe <= 1'b1;
                    task_id_res   <= pend_id;
                    event_kind    <= ptt_pkg::EV_FIRED;
                    last          <= 1'b0;
                  end
                  pend_vld <= 1'b1;
                  pend_id  <= rd_entry.id;
                  fire_cnt <= fire_cnt + 1'b1;
                end
              end
              default: begin
              end
            endcase
            if (eval_idx == LAST_IDX) begin
              state <= ST_DONE;
            end
          end
        end

        ST_DONE: begin
          state <= ST_IDLE;
          case (cmd_q)
            ptt_pkg::CMD_ADD: begin
              result_strobe <= 1'b1;
              task_id_res   <= id_q;
              last          <= 1'b1;
              if (match_found) begin
                event_kind <= ptt_pkg::EV_DUPLICATE;
              end else if (free_found) begin
                event_kind           <= ptt_pkg::EV_ADDED;
                slot_valid[free_idx] <= 1'b1;
              end else begin
                event_kind <= ptt_pkg::EV_FULL;
              end
            end
            ptt_pkg::CMD_REMOVE: begin
              result_strobe <= 1'b1;
              task_id_res   <= id_q;
              last          <= 1'b1;
              event_kind    <= match_found ? ptt_pkg::EV_REMOVED : ptt_pkg::EV_NOTFOUND;
            end
            ptt_pkg::CMD_TICK: begin
              if (pend_vld) begin
                result_strobe <= 1'b1;
                task_id_res   <= pend_id;
                event_kind    <= ptt_pkg::EV_FIRED;
                last          <= 1'b1;
              end
              pend_vld <= 1'b0;
            end
            default: begin
            end
          endcase
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The final result of a command always leaves the block free for the next one.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |-> !busy)
    else $error("final result while still busy");

  // Fired results come only from a tick.
  a_fired_tick: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (event_kind == ptt_pkg::EV_FIRED) |-> (cmd_q == ptt_pkg::CMD_TICK))
    else $error("fired result outside a tick");

  // Any table command other than a one-shot run starts a scan.
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command != ptt_pkg::CMD_ONESHOT) |=> busy)
    else $error("table command did not start a scan");

  // The slot memory is written only by a scan or by an add commit.
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_SCAN) || (state == ST_DONE))
    else $error("slot memory written while idle");

  // The per-tick result budget is never exceeded.
  a_fire_budget: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (fire_cnt <= ptt_pkg::FIRE_CNT_W'(ptt_pkg::MAX_RESULTS)))
    else $error("tick fired too many slots");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the periodic task timer table core.
`timescale 1ns / 100ps

module tb;

  localparam int SLOTS        = 32;
  localparam int DIRECTED     = 15;
  localparam int RANDOM_ITEMS = 400;
  // Far above the slowest correct run: add, remove and tick each scan the whole
  // table once, and the idle gaps between commands stay short.
  localparam int CYCLE_LIMIT  = 400000;

  // One expected result as the receiver should see it.
  typedef struct {
    logic [ptt_pkg::ID_W-1:0]   id;
    logic [ptt_pkg::KIND_W-1:0] kind;
    logic                       last;
  } table_event_t;

  // Shadow of the task table. It applies every accepted command to its own copy
  // of the slots and queues the results that the command should produce, in the
  // order in which the core must send them.
  class task_table_predictor;
    bit                         valid  [SLOTS];
    bit [ptt_pkg::ID_W-1:0]     ids    [SLOTS];
    bit [ptt_pkg::PERIOD_W-1:0] period [SLOTS];
    bit [ptt_pkg::TIME_W-1:0]   due    [SLOTS];
    table_event_t               pending_events[$];
    int                         errors;
    int                         checked;
    int                         max_burst;
    int                         full_seen;

    function int lookup(input bit [ptt_pkg::ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && ids[i] == id) return i;
      return -1;
    endfunction

    // Next due time; it sticks at the largest time value instead of wrapping.
    function bit [ptt_pkg::TIME_W-1:0] reload(input bit [ptt_pkg::TIME_W-1:0] t,
                                              input bit [ptt_pkg::PERIOD_W-1:0] p);
      bit [ptt_pkg::TIME_W:0] sum;
      sum = {1'b0, t} + {{(ptt_pkg::TIME_W + 1 - ptt_pkg::PERIOD_W){1'b0}}, p};
      return sum[ptt_pkg::TIME_W] ? '1 : sum[ptt_pkg::TIME_W-1:0];
    endfunction

    function void post(input bit [ptt_pkg::ID_W-1:0] id,
                       input bit [ptt_pkg::KIND_W-1:0] kind, input bit lst);
      table_event_t ev;
      ev.id   = id;
      ev.kind = kind;
      ev.last = lst;
      pending_events = {pending_events, ev};
    endfunction

    function void accept_command(input logic [ptt_pkg::CMD_W-1:0] cmd,
                                 input logic [ptt_pkg::ID_W-1:0] id,
                                 input logic [ptt_pkg::PERIOD_W-1:0] ivl,
                                 input logic [ptt_pkg::TIME_W-1:0] t);
      int           hit;
      int           free_slot;
      int           fired;
      table_event_t tail;
      case (cmd)
        ptt_pkg::CMD_ONESHOT: post(id, ptt_pkg::EV_ONESHOT, 1'b1);
        ptt_pkg::CMD_ADD: begin
          hit = lookup(id);
          free_slot = -1;
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!valid[i]) free_slot = i;
          if (hit >= 0) begin
            post(id, ptt_pkg::EV_DUPLICATE, 1'b1);
          end else if (free_slot < 0) begin
            post(id, ptt_pkg::EV_FULL, 1'b1);
            full_seen++;
          end else begin
            valid[free_slot]  = 1'b1;
            ids[free_slot]    = id;
            period[free_slot] = ivl;
            due[free_slot]    = reload(t, ivl);
            post(id, ptt_pkg::EV_ADDED, 1'b1);
          end
        end
        ptt_pkg::CMD_REMOVE: begin
          hit = lookup(id);
          if (hit < 0) begin
            post(id, ptt_pkg::EV_NOTFOUND, 1'b1);
          end else begin
            valid[hit] = 1'b0;
            post(id, ptt_pkg::EV_REMOVED, 1'b1);
          end
        end
        ptt_pkg::CMD_TICK: begin
          fired = 0;
          for (int i = 0; i < SLOTS; i++)
            if (valid[i] && due[i] <= t && fired < ptt_pkg::MAX_RESULTS) begin
              due[i] = reload(t, period[i]);
              post(ids[i], ptt_pkg::EV_FIRED, 1'b0);
              fired++;
            end
          if (fired > 0) begin
            tail = pending_events.pop_back();
            tail.last = 1'b1;
            pending_events = {pending_events, tail};
          end
          if (fired > max_burst) max_burst = fired;
        end
      endcase
    endfunction

    function void check_event(input logic [ptt_pkg::ID_W-1:0] id,
                              input logic [ptt_pkg::KIND_W-1:0] kind,
                              input logic lst);
      table_event_t want;
      checked++;
      if (pending_events.size() == 0) begin
        $display("%0t: result with nothing pending: id=%h kind=%0d last=%b",
                 $time, id, kind, lst);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if ({want.id, want.kind, want.last} !== {id, kind, lst}) begin
        $display("%0t: mismatch: expected id=%h kind=%0d last=%b, got id=%h kind=%0d last=%b",
                 $time, want.id, want.kind, want.last, id, kind, lst);
        errors++;
      end
    endfunction
  endclass

  logic                         clk      = 1'b0;
  logic                         rst      = 1'b1;
  logic                         start    = 1'b0;
  logic [ptt_pkg::CMD_W-1:0]    command  = ptt_pkg::CMD_ONESHOT;
  logic [ptt_pkg::ID_W-1:0]     task_id  = '0;
  logic [ptt_pkg::PERIOD_W-1:0] interval = '0;
  logic [ptt_pkg::TIME_W-1:0]   now      = '0;
  logic                         busy;
  logic                         result_strobe;
  logic [ptt_pkg::ID_W-1:0]     task_id_res;
  logic [ptt_pkg::KIND_W-1:0]   event_kind;
  logic                         last;

  task_table_predictor timer_shadow = new();

  int                         cycle_count = 0;
  int                         n_sent      = 0;
  int                         cmd_seen[4];
  bit                         no_idle     = 1'b0;
  logic [ptt_pkg::TIME_W-1:0] clock_s     = '0;

  periodic_task_timer_table_core #(.SLOTS(SLOTS)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .task_id       (task_id),
    .interval      (interval),
    .now           (now),
    .result_strobe (result_strobe),
    .task_id_res   (task_id_res),
    .event_kind    (event_kind),
    .last          (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Results cannot be held off, so every strobe is one transfer and is checked
  // against the oldest pending expectation at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && result_strobe)
      timer_shadow.check_event(task_id_res, event_kind, last);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, timer_shadow.pending_events.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Presents one command and returns at the edge where it is transferred, that
  // is, where start is high and busy is low. Before the command, start may drop
  // for a random gap: mostly none or a short one, now and then a long one, so
  // gaps land on every phase of the table scan. When no gap is taken, start
  // stays high straight into the next command.
  task automatic issue(input logic [ptt_pkg::CMD_W-1:0] cmd,
                       input logic [ptt_pkg::ID_W-1:0] id,
                       input logic [ptt_pkg::PERIOD_W-1:0] ivl,
                       input logic [ptt_pkg::TIME_W-1:0] t);
    int gap;
    int roll;
    roll = $urandom_range(0, 9);
    if (no_idle || roll < 6) gap = 0;
    else if (roll < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    command  <= cmd;
    task_id  <= id;
    interval <= ivl;
    now      <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    timer_shadow.accept_command(cmd, id, ivl, t);
    cmd_seen[cmd]++;
    n_sent++;
  endtask

  // Picks an id for add or remove: often one that is live in the table so that
  // duplicates and removals happen, sometimes one from a tiny set so that ids
  // collide, and otherwise any 16-bit value.
  function automatic logic [ptt_pkg::ID_W-1:0] choose_id();
    int live[$];
    for (int i = 0; i < SLOTS; i++)
      if (timer_shadow.valid[i]) live = {live, i};
    case ($urandom_range(0, 3))
      0, 1: if (live.size() > 0)
              return timer_shadow.ids[live[$urandom_range(0, live.size() - 1)]];
      2: return ptt_pkg::ID_W'($urandom_range(0, 7));
      default: ;
    endcase
    return ptt_pkg::ID_W'($urandom());
  endfunction

  initial begin
    int                           roll;
    int                           full_mark;
    logic [ptt_pkg::ID_W-1:0]     fresh;
    logic [ptt_pkg::PERIOD_W-1:0] ivl;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: quiet tick on an empty table, one-shots at the id
    // extremes, removal of an absent id, duplicate add, saturating due times,
    // ticks that fire some and then all tasks, and reuse of a freed slot.
    issue(ptt_pkg::CMD_TICK,    16'h0000, 20'h00000, 32'h0000_0000);
    issue(ptt_pkg::CMD_ONESHOT, 16'h0000, 20'hFFFFF, 32'hFFFF_FFFF);
    issue(ptt_pkg::CMD_ONESHOT, 16'hFFFF, 20'h00000, 32'h0000_0000);
    issue(ptt_pkg::CMD_REMOVE,  16'h1234, 20'h00000, 32'h0000_0000);
    issue(ptt_pkg::CMD_ADD,     16'h0000, 20'h00000, 32'h0000_0000);
    issue(ptt_pkg::CMD_ADD,     16'h0000, 20'h00005, 32'h0000_0001);
    issue(ptt_pkg::CMD_ADD,     16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
    issue(ptt_pkg::CMD_ADD,     16'h5A5A, 20'h00003, 32'h0000_000A);
    issue(ptt_pkg::CMD_TICK,    16'hFFFF, 20'hFFFFF, 32'h0000_000C);
    issue(ptt_pkg::CMD_TICK,    16'h0000, 20'h00000, 32'h0000_000D);
    issue(ptt_pkg::CMD_TICK,    16'hAAAA, 20'h55555, 32'hFFFF_FFFF);
    issue(ptt_pkg::CMD_REMOVE,  16'hFFFF, 20'h00000, 32'h0000_0000);
    issue(ptt_pkg::CMD_REMOVE,  16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
    issue(ptt_pkg::CMD_ADD,     16'hA5A5, 20'h00001, 32'hFFFF_FFFF);
    issue(ptt_pkg::CMD_ONESHOT, 16'h8000, 20'h80000, 32'h8000_0000);

    // Random part in episodes. Some stretches run with no idling at all.
    clock_s = 32'd20;
    while (n_sent < DIRECTED + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        // Fill the table with short-period tasks until an add is refused as
        // full, try one more add, often a duplicate, while full, then tick so all the
        // new tasks fire in one burst, and free part of the table again.
        if (clock_s > 32'hF000_0000) clock_s = $urandom_range(0, 1000);
        full_mark = timer_shadow.full_seen;
        while (timer_shadow.full_seen == full_mark) begin
          do fresh = ptt_pkg::ID_W'($urandom()); while (timer_shadow.lookup(fresh) >= 0);
          issue(ptt_pkg::CMD_ADD, fresh, ptt_pkg::PERIOD_W'($urandom_range(0, 3)),
                clock_s);
        end
        issue(ptt_pkg::CMD_ADD, choose_id(), ptt_pkg::PERIOD_W'($urandom()), clock_s);
        clock_s += 4;
        issue(ptt_pkg::CMD_TICK, ptt_pkg::ID_W'($urandom()),
              ptt_pkg::PERIOD_W'($urandom()), clock_s);
        repeat (16)
          issue(ptt_pkg::CMD_REMOVE, choose_id(), ptt_pkg::PERIOD_W'($urandom()),
                $urandom());
      end else begin
        // Mixed traffic with a mostly advancing clock, so that tasks fall due,
        // and the odd jump to a random or nearly maximal time.
        repeat (20) begin
          roll = $urandom_range(0, 19);
          if (roll < 3) begin
            issue(ptt_pkg::CMD_ONESHOT, ptt_pkg::ID_W'($urandom()),
                  ptt_pkg::PERIOD_W'($urandom()), $urandom());
          end else if (roll < 9) begin
            case ($urandom_range(0, 9))
              0: ivl = ptt_pkg::PERIOD_W'($urandom());
              1: ivl = '1;
              default: ivl = ptt_pkg::PERIOD_W'($urandom_range(0, 12));
            endcase
            issue(ptt_pkg::CMD_ADD, choose_id(), ivl, clock_s);
          end else if (roll < 14) begin
            issue(ptt_pkg::CMD_REMOVE, choose_id(), ptt_pkg::PERIOD_W'($urandom()),
                  $urandom());
          end else begin
            case ($urandom_range(0, 31))
              0: clock_s = $urandom();
              1: clock_s = 32'hFFFF_FFF0 | ptt_pkg::TIME_W'($urandom_range(0, 15));
              default: clock_s += $urandom_range(0, 6);
            endcase
            issue(ptt_pkg::CMD_TICK, ptt_pkg::ID_W'($urandom()),
                  ptt_pkg::PERIOD_W'($urandom()), clock_s);
          end
        end
      end
    end
    start <= 1'b0;

    // Drain: wait for every pending result, then give the core time to show
    // anything extra it might still send after a full table scan.
    while (timer_shadow.pending_events.size() != 0) @(posedge clk);
    repeat (SLOTS + 16) @(posedge clk);

    $display("Sent %0d commands: %0d one-shot, %0d add, %0d remove, %0d tick.",
             n_sent, cmd_seen[ptt_pkg::CMD_ONESHOT], cmd_seen[ptt_pkg::CMD_ADD],
             cmd_seen[ptt_pkg::CMD_REMOVE], cmd_seen[ptt_pkg::CMD_TICK]);
    $display("Checked %0d results; largest tick burst %0d; table-full refusals %0d.",
             timer_shadow.checked, timer_shadow.max_burst, timer_shadow.full_seen);
    if (timer_shadow.errors == 0 && timer_shadow.pending_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ptt_pkg.sv
sv/ptt_alu.sv
sv/ptt_mem.sv
sv/periodic_task_timer_table_core.sv
test/tb.sv
